// ===== hdl/btl_pkg.sv =====
// Shared sizes, payload words and controller commands for the trace log.
// Used by btl_ctrl, btl_dpath and the top level; depends on nothing.
package btl_pkg;

  localparam int BLOCKS    = 8;
  localparam int PER_BLOCK = 16;

  localparam int BLK_W     = $clog2(BLOCKS);
  localparam int CNT_W     = $clog2(BLOCKS + 1);
  localparam int FILL_W    = $clog2(PER_BLOCK + 1);
  localparam int REC_DEPTH = BLOCKS * PER_BLOCK;
  localparam int REC_W     = $clog2(REC_DEPTH);

  typedef struct packed {
    logic        func;
    logic [7:0]  thread_id;
    logic [15:0] message_id;
    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [31:0] timestamp;
  } btl_in_t;

  typedef struct packed {
    logic        status;
    logic        gap_made;
    logic        is_gap_marker;
    logic [7:0]  thread_out;
    logic [15:0] message_out;
    logic [31:0] arg1_out;
    logic [31:0] arg2_out;
    logic [31:0] timestamp_out;
  } btl_out_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_SEL_TAIL,
    CMD_TAKE_FREE,
    CMD_PUSH_DATA,
    CMD_WRITE_REC,
    CMD_SEL_SWAP,
    CMD_UNLINK_SWAP,
    CMD_PUSH_SWAP,
    CMD_MARK,
    CMD_PLACE,
    CMD_EMPTY,
    CMD_RD_ADDR,
    CMD_RD_TAKE,
    CMD_UNLINK_RD,
    CMD_PUSH_FREE
  } btl_cmd_e;

  typedef struct packed {
    logic is_read;
    logic data_empty;
    logic free_empty;
    logic blk_full;
    logic drained;
  } btl_stat_t;

endpackage

// ===== hdl/btl_dpath.sv =====
// Datapath of the trace log: record memories, block lists, fill counters, words.
// Executes one btl_pkg command per cycle; depends on btl_pkg.
module btl_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btl_pkg::btl_cmd_e cmd_i,
  output btl_pkg::btl_stat_t stat_o,
  input  btl_pkg::btl_in_t  in_data_i,
  input  logic [7:0]        ovf_tid_i,
  output btl_pkg::btl_out_t out_data_o
);
  import btl_pkg::*;

  localparam logic LDATA = 1'b0;
  localparam logic LFREE = 1'b1;

  typedef struct packed {
    logic        mark;
    logic [7:0]  thread;
    logic [15:0] msg;
    logic [31:0] a1;
    logic [31:0] a2;
  } rec_t;

  function automatic logic [REC_W-1:0] rec_addr(input logic [BLK_W-1:0] blk,
                                                input logic [FILL_W-1:0] pos);
    rec_addr = REC_W'(REC_W'(blk) * REC_W'(PER_BLOCK)) + REC_W'(pos);
  endfunction

  rec_t        rec_mem [REC_DEPTH];
  logic [31:0] tm_mem  [REC_DEPTH];

  logic [BLK_W-1:0]  nxt_q  [BLOCKS];
  logic [BLK_W-1:0]  prv_q  [BLOCKS];
  logic [FILL_W-1:0] fill_q [BLOCKS];
  logic [FILL_W-1:0] rpos_q [BLOCKS];
  logic [BLK_W-1:0]  head_q [2];
  logic [BLK_W-1:0]  tail_q [2];
  logic [CNT_W-1:0]  cnt_q  [2];

  logic [BLK_W-1:0]  b_q, swap_q;
  logic [FILL_W-1:0] pos_q;
  btl_in_t           in_q;
  btl_out_t          out_q;
  rec_t              rd_rec_q;
  logic [31:0]       rd_tm_q;

  logic              do_unlink, do_push, ul_ok, lsel;
  logic [BLK_W-1:0]  lblk, prv_rd, nxt_rd;
  logic [FILL_W-1:0] fill_b, rpos_hd, pos_sel, pos_inc;
  logic              wr_en, tm_en, rd_en;
  logic [REC_W-1:0]  wa, ra;
  rec_t              wr_rec;
  logic [32:0]       loss_sum;
  logic [31:0]       loss;

  // List operation decode: one unlink or one push per cycle.
  always_comb begin
    do_unlink = 1'b0;
    do_push   = 1'b0;
    lsel      = LDATA;
    lblk      = b_q;
    case (cmd_i)
      CMD_TAKE_FREE: begin
        do_unlink = 1'b1;
        lsel      = LFREE;
        lblk      = head_q[LFREE];
      end
      CMD_PUSH_DATA:   do_push = 1'b1;
      CMD_UNLINK_SWAP: begin
        do_unlink = 1'b1;
        lblk      = swap_q;
      end
      CMD_PUSH_SWAP: begin
        do_push = 1'b1;
        lblk    = swap_q;
      end
      CMD_UNLINK_RD:   do_unlink = 1'b1;
      CMD_PUSH_FREE: begin
        do_push = 1'b1;
        lsel    = LFREE;
      end
      default: ;
    endcase
  end

  assign prv_rd  = prv_q[lblk];
  assign nxt_rd  = nxt_q[lblk];
  assign ul_ok   = do_unlink && (cnt_q[lsel] != '0);
  assign fill_b  = fill_q[b_q];
  assign rpos_hd = rpos_q[head_q[LDATA]];
  assign pos_sel = (rpos_hd >= FILL_W'(PER_BLOCK)) ? FILL_W'(PER_BLOCK - 1) : rpos_hd;
  assign pos_inc = pos_q + FILL_W'(1);

  // A marker absorbing an older marker carries both counts.
  assign loss_sum = {1'b0, rd_rec_q.a1} + 33'(PER_BLOCK);
  assign loss     = !rd_rec_q.mark ? 32'(PER_BLOCK + 1) :
                    loss_sum[32]   ? '1 : loss_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOCKS; i++) begin
        nxt_q[i] <= (i == BLOCKS - 1) ? BLK_W'(i) : BLK_W'(i + 1);
        prv_q[i] <= (i == 0) ? '0 : BLK_W'(i - 1);
      end
      head_q[LDATA] <= '0;
      tail_q[LDATA] <= '0;
      cnt_q[LDATA]  <= '0;
      head_q[LFREE] <= '0;
      tail_q[LFREE] <= BLK_W'(BLOCKS - 1);
      cnt_q[LFREE]  <= CNT_W'(BLOCKS);
    end else begin
      if (ul_ok) begin
        if (head_q[lsel] == lblk) begin
          head_q[lsel] <= nxt_rd;
        end else begin
          nxt_q[prv_rd] <= nxt_rd;
        end
        if (tail_q[lsel] == lblk) begin
          tail_q[lsel] <= prv_rd;
        end else begin
          prv_q[nxt_rd] <= prv_rd;
        end
        cnt_q[lsel] <= cnt_q[lsel] - CNT_W'(1);
      end
      if (do_push) begin
        if (cnt_q[lsel] == '0) begin
          head_q[lsel] <= lblk;
        end else begin
          nxt_q[tail_q[lsel]] <= lblk;
        end
        prv_q[lblk]  <= tail_q[lsel];
        nxt_q[lblk]  <= lblk;
        tail_q[lsel] <= lblk;
        cnt_q[lsel]  <= cnt_q[lsel] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOCKS; i++) begin
        fill_q[i] <= '0;
        rpos_q[i] <= '0;
      end
    end else begin
      case (cmd_i)
        CMD_WRITE_REC: fill_q[b_q] <= fill_b + FILL_W'(1);
        CMD_PLACE: begin
          fill_q[swap_q] <= FILL_W'(1);
          rpos_q[swap_q] <= '0;
        end
        CMD_RD_TAKE: rpos_q[b_q] <= pos_inc;
        CMD_UNLINK_RD: begin
          fill_q[b_q] <= '0;
          rpos_q[b_q] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Record memory port selection.
  always_comb begin
    wr_en  = 1'b0;
    tm_en  = 1'b0;
    rd_en  = 1'b0;
    wa     = rec_addr(b_q, fill_b);
    ra     = rec_addr(head_q[LDATA], pos_sel);
    wr_rec = '{mark: 1'b0, thread: in_q.thread_id, msg: in_q.message_id,
               a1: in_q.arg1, a2: in_q.arg2};
    case (cmd_i)
      CMD_WRITE_REC: begin
        wr_en = 1'b1;
        tm_en = 1'b1;
      end
      CMD_MARK: begin
        wr_en  = 1'b1;
        wa     = rec_addr(b_q, '0);
        wr_rec = '{mark: 1'b1, thread: ovf_tid_i, msg: '0, a1: loss, a2: '0};
      end
      CMD_PLACE: begin
        wr_en = 1'b1;
        tm_en = 1'b1;
        wa    = rec_addr(swap_q, '0);
      end
      CMD_SEL_SWAP: begin
        rd_en = 1'b1;
        ra    = rec_addr(prv_rd, '0);
      end
      CMD_RD_ADDR: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[wa] <= wr_rec;
    end
    if (tm_en) begin
      tm_mem[wa] <= in_q.timestamp;
    end
    if (rd_en) begin
      rd_rec_q <= rec_mem[ra];
      rd_tm_q  <= tm_mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH:    in_q <= in_data_i;
      CMD_SEL_TAIL: b_q  <= tail_q[LDATA];
      CMD_TAKE_FREE: b_q <= head_q[LFREE];
      CMD_SEL_SWAP: swap_q <= prv_rd;
      CMD_RD_ADDR: begin
        b_q   <= head_q[LDATA];
        pos_q <= pos_sel;
      end
      default: ;
    endcase
  end

  // Result word, loaded only when the controller sees the output free.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_WRITE_REC: out_q <= '0;
      CMD_PLACE: begin
        out_q <= '{status: 1'b0, gap_made: 1'b1, is_gap_marker: 1'b0,
                   thread_out: '0, message_out: '0, arg1_out: '0,
                   arg2_out: '0, timestamp_out: '0};
      end
      CMD_EMPTY: begin
        out_q <= '{status: 1'b1, gap_made: 1'b0, is_gap_marker: 1'b0,
                   thread_out: '0, message_out: '0, arg1_out: '0,
                   arg2_out: '0, timestamp_out: '0};
      end
      CMD_RD_TAKE: begin
        out_q.status        <= 1'b0;
        out_q.gap_made      <= 1'b0;
        out_q.is_gap_marker <= rd_rec_q.mark;
        out_q.thread_out    <= rd_rec_q.thread;
        out_q.message_out   <= rd_rec_q.msg;
        out_q.arg1_out      <= rd_rec_q.a1;
        out_q.arg2_out      <= rd_rec_q.a2;
        out_q.timestamp_out <= rd_tm_q;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

  assign stat_o.is_read    = in_q.func;
  assign stat_o.data_empty = (cnt_q[LDATA] == '0);
  assign stat_o.free_empty = (cnt_q[LFREE] == '0);
  assign stat_o.blk_full   = (fill_b >= FILL_W'(PER_BLOCK));
  assign stat_o.drained    = (pos_inc >= fill_b);

`ifndef ASSERT_OFF
  a_swap_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_SEL_SWAP) |-> (cnt_q[LFREE] == '0))
    else $error("block recycled while a free block exists");
  a_write_within_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_WRITE_REC) |-> (fill_b < FILL_W'(PER_BLOCK)))
    else $error("record written past end of block");
  a_read_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_RD_TAKE) |-> (pos_q < fill_b))
    else $error("read position beyond block fill");
`endif

endmodule

// ===== hdl/btl_ctrl.sv =====
// Controller of the trace log: sequences list, memory and result commands.
// Drives btl_dpath through btl_pkg commands; depends on btl_pkg.
module btl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  btl_pkg::btl_stat_t stat_i,
  output btl_pkg::btl_cmd_e  cmd_o
);
  import btl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_CHECK,
    S_UNLINK_SWAP,
    S_PUSH_SWAP,
    S_MARK,
    S_PLACE,
    S_EMPTY,
    S_RD_TAKE,
    S_RD_UNLINK,
    S_RD_FREE
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q;
  logic     out_load, out_busy;
  btl_cmd_e cmd;

  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    cmd      = CMD_NOP;
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_read) begin
          if (stat_i.data_empty) begin
            state_d = S_EMPTY;
          end else begin
            cmd     = CMD_RD_ADDR;
            state_d = S_RD_TAKE;
          end
        end else if (stat_i.data_empty) begin
          cmd     = CMD_TAKE_FREE;
          state_d = S_PUSH;
        end else begin
          cmd     = CMD_SEL_TAIL;
          state_d = S_CHECK;
        end
      end
      S_PUSH: begin
        cmd     = CMD_PUSH_DATA;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.blk_full) begin
          if (!stat_i.free_empty) begin
            cmd     = CMD_TAKE_FREE;
            state_d = S_PUSH;
          end else begin
            cmd     = CMD_SEL_SWAP;
            state_d = S_UNLINK_SWAP;
          end
        end else if (!out_busy) begin
          cmd      = CMD_WRITE_REC;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_UNLINK_SWAP: begin
        cmd     = CMD_UNLINK_SWAP;
        state_d = S_PUSH_SWAP;
      end
      S_PUSH_SWAP: begin
        cmd     = CMD_PUSH_SWAP;
        state_d = S_MARK;
      end
      S_MARK: begin
        cmd     = CMD_MARK;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        if (!out_busy) begin
          cmd      = CMD_PLACE;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (!out_busy) begin
          cmd      = CMD_EMPTY;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_RD_TAKE: begin
        if (!out_busy) begin
          cmd      = CMD_RD_TAKE;
          out_load = 1'b1;
          state_d  = stat_i.drained ? S_RD_UNLINK : S_IDLE;
        end
      end
      S_RD_UNLINK: begin
        cmd     = CMD_UNLINK_RD;
        state_d = S_RD_FREE;
      end
      S_RD_FREE: begin
        cmd     = CMD_PUSH_FREE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result word overwritten while stalled");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word accepted before the first finished");
  a_push_follows_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_PUSH_DATA) |-> ($past(cmd) == CMD_TAKE_FREE))
    else $error("block pushed to data list without leaving free list");
`endif

endmodule

// ===== hdl/block_trace_log_with_gap_marker_top.sv =====
// Trace log with gap marker: input and result channels use valid/stall.
// Each input word is an append (func 0) or a read of the oldest record (func 1);
// every input word yields exactly one result word, in order.
// An append returns status 0 and gap_made; gap_made is 1 when the log was full
// and the second-newest block was recycled behind a gap marker. A read returns
// the oldest record, or status 1 with all other fields 0 when the log is empty.
// Sequence: a plain append selects the tail block and writes the record; a read
// addresses and takes the oldest record; an append into an empty log first takes
// a free block onto the data list; an append that opens a new block does so after
// finding the tail full; an append that recycles a block selects, unlinks and
// re-pushes the second-newest block, writes the marker and places the record. A
// read that drains a block keeps the input stalled while it returns the block to
// the free list. One word is processed at a time, to the end of its sequence.
// A stalled result word holds; the input is taken again once the result sits in
// the output register, and completion waits while that register is still stalled.
// Reset empties the log (all blocks free) and sets the marker thread register to
// 255; record memory contents are not cleared. The marker thread register sits at
// APB address 0 and should be written only while the block is idle.
module block_trace_log_with_gap_marker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  btl_pkg::btl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output btl_pkg::btl_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import btl_pkg::*;

  localparam logic REG_OVF_TID = 1'b0;

  logic [7:0] ovf_tid_val_q;
  btl_stat_t  stat;
  btl_cmd_e   cmd;
  logic       reg_hit;

  assign reg_hit = (paddr[2] == REG_OVF_TID);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_tid_val_q <= 8'hFF;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ovf_tid_val_q <= pwdata[7:0];
    end
  end

  assign prdata    = reg_hit ? {24'b0, ovf_tid_val_q} : '0;
  assign pready    = 1'b1;

  btl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  btl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .ovf_tid_i  (ovf_tid_val_q),
    .out_data_o (out_data_o)
  );

endmodule
